// ===== design/hbet_pkg.sv =====
// ============================================================================
// hbet_pkg
// Shared types, constants and helpers for the HTTP body end tracker.
// ============================================================================
`default_nettype none

package hbet_pkg;

    localparam int SIZE_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 2;
    localparam int CLEN_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // body modes
    localparam logic [MODE_W-1:0] MODE_LENGTH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BODY_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTENT_LENGTH = 2'd1;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [4:0] {
        PH_SIZE = 5'b00001,  // size line digits and extension
        PH_LF   = 5'b00010,  // LF after size line
        PH_DATA = 5'b00100,  // chunk payload
        PH_CR2  = 5'b01000,  // CR after payload
        PH_LF2  = 5'b10000   // LF after payload
    } phase_t;

    typedef struct packed {
        logic digits_closed;
        logic done;
        logic error;
    } flags_t;

    typedef struct packed {
        logic body_done;
        logic framing_error;
        logic payload_valid;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== design/hbet_step.sv =====
// ============================================================================
// hbet_step
// Next-state and result logic for one body byte.
// ============================================================================
`default_nettype none

module hbet_step #(
    parameter int SIZE_BITS  = hbet_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = hbet_pkg::COUNT_BITS_DEF
) (
    input  wire logic [hbet_pkg::MODE_W-1:0] body_mode,
    input  wire logic [hbet_pkg::CLEN_W-1:0] content_length,
    input  wire logic [hbet_pkg::BYTE_W-1:0] data_byte,
    input  wire hbet_pkg::phase_t            phase,
    input  wire logic [SIZE_BITS-1:0]        chunk_size,
    input  wire logic [COUNT_BITS-1:0]       bytes_seen,
    input  wire hbet_pkg::flags_t            flags,
    output hbet_pkg::phase_t                 phase_next,
    output logic [SIZE_BITS-1:0]             chunk_size_next,
    output logic [COUNT_BITS-1:0]            bytes_seen_next,
    output hbet_pkg::flags_t                 flags_next,
    output hbet_pkg::result_t                result,
    output logic [hbet_pkg::BYTE_W-1:0]      payload_byte
);
    import hbet_pkg::*;

    localparam int LEN_W = (COUNT_BITS > CLEN_W) ? COUNT_BITS : CLEN_W;
    localparam int CHK_W = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;

    logic [COUNT_BITS-1:0] bytes_inc;
    logic                  len_hit_now;
    logic                  len_hit_inc;
    logic                  chunk_hit_inc;
    hex_t                  hex;
    logic                  pay;

    // saturating byte counter
    assign bytes_inc     = (bytes_seen != {COUNT_BITS{1'b1}})
                           ? bytes_seen + COUNT_BITS'(1) : bytes_seen;
    assign len_hit_now   = LEN_W'(bytes_seen) == LEN_W'(content_length);
    assign len_hit_inc   = LEN_W'(bytes_inc) == LEN_W'(content_length);
    assign chunk_hit_inc = CHK_W'(bytes_inc) == CHK_W'(chunk_size);
    assign hex           = hex_decode(data_byte);

    always_comb begin
        phase_next      = phase;
        chunk_size_next = chunk_size;
        bytes_seen_next = bytes_seen;
        flags_next      = flags;
        pay             = 1'b0;

        priority if (flags.error) begin
            // frozen until reset
        end else if (body_mode != MODE_LENGTH && body_mode != MODE_CHUNKED) begin
            flags_next.done  = 1'b1;
            flags_next.error = 1'b1;
        end else if (flags.done) begin
            flags_next.error = 1'b1;
        end else if (body_mode == MODE_LENGTH) begin
            if (len_hit_now) begin
                flags_next.done  = 1'b1;
                flags_next.error = 1'b1;
            end else begin
                pay             = 1'b1;
                bytes_seen_next = bytes_inc;
                if (len_hit_inc) begin
                    flags_next.done = 1'b1;
                end
            end
        end else begin
            unique case (phase)
                PH_SIZE: begin
                    if (data_byte == CHAR_CR) begin
                        flags_next.digits_closed = 1'b0;
                        if (chunk_size == '0) begin
                            flags_next.done = 1'b1;
                        end else begin
                            phase_next = PH_LF;
                        end
                    end else if (flags.digits_closed) begin
                        // extension text, skipped
                    end else if (!hex.ok) begin
                        flags_next.digits_closed = 1'b1;
                    end else if (chunk_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                        flags_next.error = 1'b1;
                    end else begin
                        chunk_size_next = {chunk_size[SIZE_BITS-5:0], hex.value};
                    end
                end
                PH_LF: begin
                    if (data_byte != CHAR_LF) begin
                        flags_next.error = 1'b1;
                    end else begin
                        bytes_seen_next = '0;
                        phase_next      = PH_DATA;
                    end
                end
                PH_DATA: begin
                    pay             = 1'b1;
                    bytes_seen_next = bytes_inc;
                    if (chunk_hit_inc) begin
                        phase_next = PH_CR2;
                    end
                end
                PH_CR2: begin
                    if (data_byte != CHAR_CR) begin
                        flags_next.error = 1'b1;
                    end else begin
                        phase_next = PH_LF2;
                    end
                end
                PH_LF2: begin
                    if (data_byte != CHAR_LF) begin
                        flags_next.error = 1'b1;
                    end else begin
                        phase_next               = PH_SIZE;
                        chunk_size_next          = '0;
                        bytes_seen_next          = '0;
                        flags_next.digits_closed = 1'b0;
                    end
                end
                default: begin
                    flags_next.error = 1'b1;
                end
            endcase
        end
    end

    assign result.body_done     = flags_next.done;
    assign result.framing_error = flags_next.error;
    assign result.payload_valid = pay;
    assign payload_byte         = pay ? data_byte : '0;

endmodule

`default_nettype wire

// ===== design/http_body_end_tracker.sv =====
// ============================================================================
// http_body_end_tracker
// Follows an HTTP message body byte by byte and flags its end.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data_byte carries one raw body byte per item.
//   m_valid/m_ready carries one result item per input byte: sticky
//   m_body_done and m_framing_error, plus m_payload_valid/m_payload_byte
//   when the byte is body payload (payload byte reads 0 otherwise).
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata writes body_mode (index 0) and
//   content_length (index 1); cfg_ready is always high. Write only while
//   no item is in flight; writes do not clear tracking state.
//   Timing: the byte lands in the input register at the accepting edge and
//   its result in the result register when it advances, raising m_valid.
//   Throughput: one byte per cycle unless a held result stalls it; the
//   combinational state update between those registers sets this.
//   Reset (aresetn low, synchronous) clears the tracker to the start of a
//   size line and drops both registers. When m_ready is low the result
//   register holds and one more byte is taken into the input register,
//   after which s_ready falls until the result is taken.
// ============================================================================
`default_nettype none

module http_body_end_tracker #(
    parameter int SIZE_BITS  = hbet_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = hbet_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [hbet_pkg::BYTE_W-1:0]      s_data_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_body_done,
    output logic                                  m_framing_error,
    output logic                                  m_payload_valid,
    output logic [hbet_pkg::BYTE_W-1:0]           m_payload_byte,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hbet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hbet_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import hbet_pkg::*;

    logic [MODE_W-1:0]     body_mode_reg;
    logic [CLEN_W-1:0]     content_length_reg;
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [SIZE_BITS-1:0]  chunk_size_reg;
    logic [SIZE_BITS-1:0]  chunk_size_next;
    logic [COUNT_BITS-1:0] bytes_seen_reg;
    logic [COUNT_BITS-1:0] bytes_seen_next;
    flags_t                flags_reg;
    flags_t                flags_next;
    result_t               result;
    logic [BYTE_W-1:0]     payload_byte;
    logic                  out_valid_reg;
    result_t               out_result_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  s_accept;
    logic                  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_mode_reg      <= MODE_LENGTH;
            content_length_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BODY_MODE:      body_mode_reg      <= cfg_wdata[MODE_W-1:0];
                CFG_CONTENT_LENGTH: content_length_reg <= cfg_wdata[CLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_data_byte;
        end
    end

    hbet_step #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .body_mode       (body_mode_reg),
        .content_length  (content_length_reg),
        .data_byte       (in_byte_reg),
        .phase           (phase_reg),
        .chunk_size      (chunk_size_reg),
        .bytes_seen      (bytes_seen_reg),
        .flags           (flags_reg),
        .phase_next      (phase_next),
        .chunk_size_next (chunk_size_next),
        .bytes_seen_next (bytes_seen_next),
        .flags_next      (flags_next),
        .result          (result),
        .payload_byte    (payload_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            chunk_size_reg <= '0;
            bytes_seen_reg <= '0;
            flags_reg      <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            chunk_size_reg <= chunk_size_next;
            bytes_seen_reg <= bytes_seen_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
            out_byte_reg   <= payload_byte;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_body_done     = out_result_reg.body_done;
    assign m_framing_error = out_result_reg.framing_error;
    assign m_payload_valid = out_result_reg.payload_valid;
    assign m_payload_byte  = out_byte_reg;

`ifndef SYNTHESIS
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.error |=> flags_reg.error)
        else $error("framing error flag cleared without reset");

    a_no_payload_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && flags_reg.done |=> m_valid && !m_payload_valid && m_body_done)
        else $error("payload reported after body end");

    a_error_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_framing_error |-> !m_payload_valid)
        else $error("payload reported together with framing error");

    a_zero_byte_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload_valid |-> m_payload_byte == '0)
        else $error("payload byte nonzero on non-payload item");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input item lost or changed");
`endif

endmodule

`default_nettype wire
